[rtl/core/bqe_pkg.sv]
package bqe_pkg;

  localparam int PosW = 20;
  localparam int VecW = 16;
  localparam int OrdW = 30;
  localparam int VnW  = 32;
  localparam int CfgW = 60;
  localparam int IdxW = 3;
  localparam int SqW  = 32;   // root width of a 64-bit radicand
  localparam int RadW = 64;
  localparam int QW   = 24;   // quotient width, enough above the clamp
  localparam int NumW = 64;

  localparam logic signed [VecW-1:0] OneQ14 = 16'sd16384;
  localparam logic signed [PosW+2:0] PosMax = 23'sd524287;
  localparam logic signed [PosW+2:0] PosMin = -23'sd524288;

  localparam logic [IdxW-1:0] RegMode   = 3'd0;
  localparam logic [IdxW-1:0] RegRight  = 3'd1;
  localparam logic [IdxW-1:0] RegUp     = 3'd2;
  localparam logic [IdxW-1:0] RegCam    = 3'd3;
  localparam logic [IdxW-1:0] RegWidth  = 3'd4;
  localparam logic [IdxW-1:0] RegHeight = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOADV, ST_SUM, ST_SQRT, ST_DIVINIT, ST_DIV, ST_NEXTC,
    ST_NEXTV, ST_HALF, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load_item;  // capture centre, set up first vector
    logic       load_vec;   // load the vector to normalise (0 right, 1 up)
    logic       vec_sel;
    logic       sum_sq;     // square and accumulate one component
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       store_n;    // store normalised component
    logic [1:0] comp;
    logic       half;       // compute half offsets
    logic       out_load;
    logic [1:0] corner;
  } cmd_t;

  typedef struct packed {
    logic skip_norm;   // vector fixed or zero, no normalise
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

[rtl/core/billboard_quad_expander.sv]
// channel  ports                                         direction
// input    in_valid in_stall in_center_x/y/z in_first_of_batch   in
// output   out_valid out_stall out_corner out_pos_x/y/z ... last  out
// config   cfg_we cfg_index cfg_data                     in
//
// a sprite needs no normalisation in cylindrical mode with the camera above
// centre; otherwise each vector that is not fixed or zero goes through the
// shared bit-serial square root and divider
// four corners leave the output register at one a cycle while not stalled
// reset is synchronous and active low; config returns to reset values
// out_stall holds the output word; input stalls until the fourth is loaded
module billboard_quad_expander (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bqe_pkg::IdxW-1:0]          cfg_index,
  input  logic [bqe_pkg::CfgW-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [bqe_pkg::PosW-1:0]   in_center_x,
  input  logic signed [bqe_pkg::PosW-1:0]   in_center_y,
  input  logic signed [bqe_pkg::PosW-1:0]   in_center_z,
  input  logic                              in_first_of_batch,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_corner,
  output logic signed [bqe_pkg::PosW-1:0]   out_pos_x,
  output logic signed [bqe_pkg::PosW-1:0]   out_pos_y,
  output logic signed [bqe_pkg::PosW-1:0]   out_pos_z,
  output logic                              out_tex_u,
  output logic                              out_tex_v,
  output logic [bqe_pkg::VnW-1:0]           out_vertex_number,
  output logic                              out_last
);

  bqe_pkg::cmd_t cmd;
  bqe_pkg::sts_t sts;

  bqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sts       (sts),
    .out_taken (out_valid && !out_stall),
    .cmd       (cmd)
  );

  bqe_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_center_z       (in_center_z),
    .in_first_of_batch (in_first_of_batch),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_corner        (out_corner),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_vertex_number (out_vertex_number),
    .out_last          (out_last)
  );

endmodule

[rtl/core/bqe_ctrl.sv]
module bqe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bqe_pkg::sts_t sts,
  input  logic          out_taken,
  output bqe_pkg::cmd_t cmd
);

  bqe_pkg::state_t state_r, state_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic       vsel_r, vsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bqe_pkg::ST_IDLE;
      comp_r   <= '0;
      corner_r <= '0;
      vsel_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      comp_r   <= comp_nxt;
      corner_r <= corner_nxt;
      vsel_r   <= vsel_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    comp_nxt   = comp_r;
    corner_nxt = corner_r;
    vsel_nxt   = vsel_r;
    cmd        = '0;
    cmd.comp   = comp_r;
    cmd.vec_sel = vsel_r;
    cmd.corner = corner_r;
    in_stall   = 1'b1;
    unique case (state_r)
      bqe_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          vsel_nxt  = 1'b0;
          state_nxt = bqe_pkg::ST_LOADV;
        end
      end
      bqe_pkg::ST_LOADV: begin
        cmd.load_vec = 1'b1;
        comp_nxt  = '0;
        state_nxt = bqe_pkg::ST_SUM;
      end
      bqe_pkg::ST_SUM: begin
        if (sts.skip_norm) begin
          state_nxt = bqe_pkg::ST_NEXTV;
        end else begin
          cmd.sum_sq = 1'b1;
          if (comp_r == 2'd2) begin
            state_nxt = bqe_pkg::ST_SQRT;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      bqe_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          comp_nxt  = '0;
          state_nxt = bqe_pkg::ST_DIVINIT;
        end
      end
      bqe_pkg::ST_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_nxt = bqe_pkg::ST_DIV;
      end
      bqe_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = bqe_pkg::ST_NEXTC;
      end
      bqe_pkg::ST_NEXTC: begin
        cmd.store_n = 1'b1;
        if (comp_r == 2'd2) begin
          state_nxt = bqe_pkg::ST_NEXTV;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = bqe_pkg::ST_DIVINIT;
        end
      end
      bqe_pkg::ST_NEXTV: begin
        if (vsel_r) begin
          state_nxt = bqe_pkg::ST_HALF;
        end else begin
          vsel_nxt  = 1'b1;
          state_nxt = bqe_pkg::ST_LOADV;
        end
      end
      bqe_pkg::ST_HALF: begin
        cmd.half   = 1'b1;
        corner_nxt = '0;
        state_nxt  = bqe_pkg::ST_EMIT;
      end
      bqe_pkg::ST_EMIT: begin
        if (!sts.out_busy || out_taken) begin
          cmd.out_load = 1'b1;
          corner_nxt = corner_r + 2'd1;
          if (corner_r == 2'd3) state_nxt = bqe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bqe_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/core/bqe_dp.sv]
module bqe_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bqe_pkg::IdxW-1:0]          cfg_index,
  input  logic [bqe_pkg::CfgW-1:0]          cfg_data,
  input  logic signed [bqe_pkg::PosW-1:0]   in_center_x,
  input  logic signed [bqe_pkg::PosW-1:0]   in_center_y,
  input  logic signed [bqe_pkg::PosW-1:0]   in_center_z,
  input  logic                              in_first_of_batch,
  input  bqe_pkg::cmd_t                     cmd,
  output bqe_pkg::sts_t                     sts,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [1:0]                        out_corner,
  output logic signed [bqe_pkg::PosW-1:0]   out_pos_x,
  output logic signed [bqe_pkg::PosW-1:0]   out_pos_y,
  output logic signed [bqe_pkg::PosW-1:0]   out_pos_z,
  output logic                              out_tex_u,
  output logic                              out_tex_v,
  output logic [bqe_pkg::VnW-1:0]           out_vertex_number,
  output logic                              out_last
);

  localparam int PW = bqe_pkg::PosW;
  localparam int DW = PW + 2;  // camera difference width

  logic             mode_r;
  logic [47:0]      right_r, up_r;
  logic [59:0]      cam_r;
  logic [PW-1:0]    wid_r, hgt_r;
  logic [bqe_pkg::OrdW-1:0] ord_r, cur_ord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      right_r <= 48'd16384;
      up_r    <= 48'd1073741824;
      cam_r   <= '0;
      wid_r   <= 20'd256;
      hgt_r   <= 20'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bqe_pkg::RegMode:   mode_r  <= cfg_data[0];
        bqe_pkg::RegRight:  right_r <= cfg_data[47:0];
        bqe_pkg::RegUp:     up_r    <= cfg_data[47:0];
        bqe_pkg::RegCam:    cam_r   <= cfg_data;
        bqe_pkg::RegWidth:  wid_r   <= cfg_data[PW-1:0];
        bqe_pkg::RegHeight: hgt_r   <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  logic signed [PW-1:0] c_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= '0;
    end else if (cmd.load_item) begin
      ord_r <= (in_first_of_batch ? '0 : ord_r) + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      c_r[0]    <= in_center_x;
      c_r[1]    <= in_center_y;
      c_r[2]    <= in_center_z;
      cur_ord_r <= in_first_of_batch ? '0 : ord_r;
    end
  end

  // vector under normalisation
  logic signed [DW-1:0] v_r [3];
  logic                 skip_r;
  logic signed [DW-1:0] dx, dz, v_ld [3];
  logic signed [bqe_pkg::VecW-1:0] n_r [3];
  logic signed [bqe_pkg::VecW-1:0] r_r [3], u_r [3];
  logic [47:0] vsrc;

  assign dx = DW'($signed(cam_r[19:0])) - DW'(c_r[0]);
  assign dz = DW'($signed(cam_r[59:40])) - DW'(c_r[2]);
  assign vsrc = cmd.vec_sel ? up_r : right_r;

  always_comb begin
    if (mode_r) begin
      v_ld[0] = dz;
      v_ld[1] = '0;
      v_ld[2] = -dx;
    end else begin
      v_ld[0] = DW'($signed(vsrc[15:0]));
      v_ld[1] = DW'($signed(vsrc[31:16]));
      v_ld[2] = DW'($signed(vsrc[47:32]));
    end
  end

  logic [bqe_pkg::RadW-1:0] s_r;
  logic signed [2*DW-1:0] sq;
  assign sq = v_r[cmd.comp] * v_r[cmd.comp];

  // square root, one result bit per cycle
  logic [bqe_pkg::RadW-1:0] rem_r;
  logic [bqe_pkg::SqW-1:0]  root_r;
  logic [5:0]               sq_cnt_r;
  logic [bqe_pkg::RadW+1:0] trial;
  logic [bqe_pkg::RadW+1:0] rem_sh;
  logic [bqe_pkg::RadW-1:0] rad_r;
  assign rem_sh = {rem_r, rad_r[63:62]};
  assign trial  = rem_sh - {root_r, 2'b01};

  // restoring divide, one quotient bit per cycle
  logic [bqe_pkg::NumW-1:0] num_r;
  logic [bqe_pkg::SqW:0]    drem_r;
  logic [bqe_pkg::QW-1:0]   q_r;
  logic [5:0]               dcnt_r;
  logic                     neg_r;
  logic [bqe_pkg::SqW:0]    dsh, dtrial;
  logic [DW-1:0]            mag;
  logic [bqe_pkg::QW:0]     qr;
  logic signed [bqe_pkg::QW+1:0] qs;
  logic signed [bqe_pkg::VecW-1:0] qclamp;

  assign dsh    = {drem_r[bqe_pkg::SqW-1:0], num_r[bqe_pkg::NumW-1]};
  assign dtrial = dsh - {1'b0, root_r};
  assign mag    = v_r[cmd.comp][DW-1] ? DW'(-v_r[cmd.comp]) : DW'(v_r[cmd.comp]);
  // round half up on the magnitude: one more fraction bit in q, then add it
  assign qr     = (bqe_pkg::QW+1)'(q_r[bqe_pkg::QW-1:1]) + (bqe_pkg::QW+1)'(q_r[0]);
  always_comb begin
    qs = neg_r ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    if (qs > (bqe_pkg::QW+2)'(bqe_pkg::OneQ14)) qclamp = bqe_pkg::OneQ14;
    else if (qs < -(bqe_pkg::QW+2)'(bqe_pkg::OneQ14)) qclamp = -bqe_pkg::OneQ14;
    else qclamp = qs[bqe_pkg::VecW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vec) begin
      for (int i = 0; i < 3; i++) v_r[i] <= v_ld[i];
      s_r <= '0;
      n_r[0] <= '0; n_r[1] <= '0; n_r[2] <= '0;
      if (mode_r) begin
        skip_r <= cmd.vec_sel || (dx == '0 && dz == '0);
        if (cmd.vec_sel) begin
          n_r[1] <= bqe_pkg::OneQ14;
        end else if (dx == '0 && dz == '0) begin
          n_r[0] <= bqe_pkg::OneQ14;
        end
      end else begin
        skip_r <= (v_ld[0] == '0 && v_ld[1] == '0 && v_ld[2] == '0);
      end
    end
    if (cmd.sum_sq) begin
      s_r <= s_r + bqe_pkg::RadW'(unsigned'(sq));
      if (cmd.comp == 2'd2) begin
        rad_r    <= (s_r + bqe_pkg::RadW'(unsigned'(sq))) << 16;
        rem_r    <= '0;
        root_r   <= '0;
        sq_cnt_r <= '0;
      end
    end
    if (cmd.sqrt_step) begin
      rad_r    <= rad_r << 2;
      sq_cnt_r <= sq_cnt_r + 6'd1;
      if (!trial[bqe_pkg::RadW+1]) begin
        rem_r  <= trial[bqe_pkg::RadW-1:0];
        root_r <= {root_r[bqe_pkg::SqW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[bqe_pkg::RadW-1:0];
        root_r <= {root_r[bqe_pkg::SqW-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      // numerator mag * 2^23, one fraction bit beyond the wanted quotient
      num_r  <= bqe_pkg::NumW'(mag) << 23;
      drem_r <= '0;
      neg_r  <= v_r[cmd.comp][DW-1];
      q_r    <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      num_r  <= num_r << 1;
      dcnt_r <= dcnt_r + 6'd1;
      if (!dtrial[bqe_pkg::SqW]) begin
        drem_r <= dtrial;
        q_r    <= {q_r[bqe_pkg::QW-2:0], 1'b1};
      end else begin
        drem_r <= dsh;
        q_r    <= {q_r[bqe_pkg::QW-2:0], 1'b0};
      end
    end
    if (cmd.store_n) n_r[cmd.comp] <= qclamp;
    if (cmd.load_vec && cmd.vec_sel) begin
      for (int i = 0; i < 3; i++) r_r[i] <= skip_r && !mode_r ? '0 : n_r[i];
    end
  end

  // the right vector is copied when the up vector loads; up is read from n_r
  // a zero spherical vector leaves n_r at zero, handled by load_vec clear

  // divide length: mag * 2^23 is 22+23 = 45 bits; run 64 steps from the top
  assign sts.sqrt_done = (sq_cnt_r == 6'd31) && cmd.sqrt_step;
  assign sts.div_done  = (dcnt_r == 6'd63);
  assign sts.skip_norm = skip_r;

  // half offsets
  logic signed [PW+2:0] hr_r [3], hu_r [3];
  logic signed [bqe_pkg::VecW+PW+1:0] pr [3], pu [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i] = r_r[i] * $signed({1'b0, wid_r});
      pu[i] = n_r[i] * $signed({1'b0, hgt_r});
    end
  end

  function automatic logic signed [PW+2:0] rnd15(
    input logic signed [bqe_pkg::VecW+PW+1:0] p
  );
    logic [bqe_pkg::VecW+PW+1:0] m;
    logic [bqe_pkg::VecW+PW+1:0] q;
    m = p[bqe_pkg::VecW+PW+1] ? -p : p;
    q = (m + 37'd16384) >> 15;
    rnd15 = p[bqe_pkg::VecW+PW+1] ? -$signed(q[PW+2:0]) : $signed(q[PW+2:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.half) begin
      for (int i = 0; i < 3; i++) begin
        hr_r[i] <= rnd15(pr[i]);
        hu_r[i] <= rnd15(pu[i]);
      end
    end
  end

  // output register
  logic signed [PW+3:0] psum [3];
  logic signed [PW-1:0] psat [3];
  logic sr_neg, su_neg;
  assign sr_neg = (cmd.corner == 2'd0) || (cmd.corner == 2'd3);
  assign su_neg = (cmd.corner == 2'd0) || (cmd.corner == 2'd1);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = (PW+4)'(c_r[i])
              + (sr_neg ? -(PW+4)'(hr_r[i]) : (PW+4)'(hr_r[i]))
              + (su_neg ? -(PW+4)'(hu_r[i]) : (PW+4)'(hu_r[i]));
      if (psum[i] > (PW+4)'(bqe_pkg::PosMax)) psat[i] = bqe_pkg::PosMax[PW-1:0];
      else if (psum[i] < (PW+4)'(bqe_pkg::PosMin)) psat[i] = bqe_pkg::PosMin[PW-1:0];
      else psat[i] = psum[i][PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_corner        <= cmd.corner;
      out_pos_x         <= psat[0];
      out_pos_y         <= psat[1];
      out_pos_z         <= psat[2];
      out_tex_u         <= (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
      out_tex_v         <= cmd.corner[1];
      out_vertex_number <= {cur_ord_r, cmd.corner};
      out_last          <= (cmd.corner == 2'd3);
    end
  end
  assign sts.out_busy = out_valid;

endmodule

[test/tb_billboard_quad_expander.sv]
module tb_billboard_quad_expander;

  localparam logic [bqe_pkg::IdxW-1:0] RegUnused = 3'd6;
  localparam logic [bqe_pkg::IdxW-1:0] RegBeyond = 3'd7;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic signed [bqe_pkg::PosW-1:0] x;
    logic signed [bqe_pkg::PosW-1:0] y;
    logic signed [bqe_pkg::PosW-1:0] z;
    logic                            first;
  } sprite_t;

  typedef struct packed {
    logic [1:0]                      corner;
    logic signed [bqe_pkg::PosW-1:0] x;
    logic signed [bqe_pkg::PosW-1:0] y;
    logic signed [bqe_pkg::PosW-1:0] z;
    logic                            u;
    logic                            v;
    logic [bqe_pkg::VnW-1:0]         vn;
    logic                            last;
  } corner_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } v3_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bqe_pkg::IdxW-1:0] cfg_index = bqe_pkg::RegMode;
  logic [bqe_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [bqe_pkg::PosW-1:0] in_center_x = '0;
  logic signed [bqe_pkg::PosW-1:0] in_center_y = '0;
  logic signed [bqe_pkg::PosW-1:0] in_center_z = '0;
  logic in_first_of_batch = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_corner;
  logic signed [bqe_pkg::PosW-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_tex_u, out_tex_v;
  logic [bqe_pkg::VnW-1:0] out_vertex_number;
  logic out_last;

  billboard_quad_expander dut (.*);

  always #5 clk = ~clk;

  // shadow of the register file and the sprite counter
  logic        m_mode = 1'b0;
  logic [47:0] m_right = 48'd16384;
  logic [47:0] m_up = 48'd1073741824;
  logic [59:0] m_cam = '0;
  logic [19:0] m_width = 20'd256;
  logic [19:0] m_height = 20'd256;
  logic [bqe_pkg::OrdW-1:0] next_ordinal = '0;

  sprite_t sprites_waiting[$];
  corner_t corners_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit calm = 0;
  bit tail = 0;

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rounds half away from zero
  function automatic longint div_round(longint num, longint den);
    longint mag = num < 0 ? -num : num;
    longint q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint unit_comp(longint c, longint len);
    longint q = div_round(c * (64'sd1 <<< 22), len);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q;
  endfunction

  function automatic v3_t unit_vec(v3_t v);
    longint unsigned s = v.x * v.x + v.y * v.y + v.z * v.z;
    longint len;
    v3_t n = '0;
    if (s == 0) return n;
    len = sqrt_floor(s << 16);
    n.x = unit_comp(v.x, len);
    n.y = unit_comp(v.y, len);
    n.z = unit_comp(v.z, len);
    return n;
  endfunction

  function automatic logic signed [bqe_pkg::PosW-1:0] clip_pos(longint p);
    if (p > 524287) return 20'sd524287;
    if (p < -524288) return -20'sd524288;
    return p[bqe_pkg::PosW-1:0];
  endfunction

  function automatic v3_t unpack_q14(logic [47:0] r);
    v3_t v;
    v.x = 64'($signed(r[15:0]));
    v.y = 64'($signed(r[31:16]));
    v.z = 64'($signed(r[47:32]));
    return v;
  endfunction

  task automatic expand_sprite(sprite_t s);
    v3_t rv, uv, d, hr, hu;
    logic signed [63:0] cx, cz;
    logic [bqe_pkg::OrdW-1:0] ord;
    corner_t c;
    longint sr, su;
    if (m_mode) begin
      cx = 64'($signed(m_cam[19:0]));
      cz = 64'($signed(m_cam[59:40]));
      d.x = cz - s.z;
      d.y = 0;
      d.z = -(cx - s.x);
      if (d.x == 0 && d.z == 0) begin
        rv.x = 16384; rv.y = 0; rv.z = 0;
      end else begin
        rv = unit_vec(d);
      end
      uv.x = 0; uv.y = 16384; uv.z = 0;
    end else begin
      rv = unit_vec(unpack_q14(m_right));
      uv = unit_vec(unpack_q14(m_up));
    end
    hr.x = div_round(rv.x * longint'(m_width), 32768);
    hr.y = div_round(rv.y * longint'(m_width), 32768);
    hr.z = div_round(rv.z * longint'(m_width), 32768);
    hu.x = div_round(uv.x * longint'(m_height), 32768);
    hu.y = div_round(uv.y * longint'(m_height), 32768);
    hu.z = div_round(uv.z * longint'(m_height), 32768);
    ord = s.first ? '0 : next_ordinal;
    next_ordinal = ord + 1'b1;
    for (int k = 0; k < 4; k++) begin
      sr = (k == 1 || k == 2) ? 1 : -1;
      su = (k >= 2) ? 1 : -1;
      c.corner = k[1:0];
      c.x = clip_pos(longint'(s.x) + sr * hr.x + su * hu.x);
      c.y = clip_pos(longint'(s.y) + sr * hr.y + su * hu.y);
      c.z = clip_pos(longint'(s.z) + sr * hr.z + su * hu.z);
      c.u = (k == 1 || k == 2);
      c.v = (k >= 2);
      c.vn = {ord, k[1:0]};
      c.last = (k == 3);
      corners_due.push_back(c);
    end
  endtask

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) begin
        expand_sprite(sprites_waiting.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (sprites_waiting.size() > 0) begin
        in_valid <= 1'b1;
        in_center_x <= sprites_waiting[0].x;
        in_center_y <= sprites_waiting[0].y;
        in_center_z <= sprites_waiting[0].z;
        in_first_of_batch <= sprites_waiting[0].first;
        if (!tail && !calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    corner_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (corners_due.size() == 0) begin
        report("corner word with nothing expected");
      end else begin
        e = corners_due.pop_front();
        if (out_corner !== e.corner) report($sformatf("corner %0d exp %0d", out_corner, e.corner));
        if (out_pos_x !== e.x) report($sformatf("pos_x %0d exp %0d", out_pos_x, e.x));
        if (out_pos_y !== e.y) report($sformatf("pos_y %0d exp %0d", out_pos_y, e.y));
        if (out_pos_z !== e.z) report($sformatf("pos_z %0d exp %0d", out_pos_z, e.z));
        if (out_tex_u !== e.u) report($sformatf("tex_u %0b exp %0b", out_tex_u, e.u));
        if (out_tex_v !== e.v) report($sformatf("tex_v %0b exp %0b", out_tex_v, e.v));
        if (out_vertex_number !== e.vn)
          report($sformatf("vertex_number %0d exp %0d", out_vertex_number, e.vn));
        if (out_last !== e.last) report($sformatf("last %0b exp %0b", out_last, e.last));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!tail && !calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic wait_drained();
    while (sprites_waiting.size() != 0 || in_valid || corners_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [bqe_pkg::IdxW-1:0] idx, logic [bqe_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bqe_pkg::RegMode:   m_mode = val[0];
      bqe_pkg::RegRight:  m_right = val[47:0];
      bqe_pkg::RegUp:     m_up = val[47:0];
      bqe_pkg::RegCam:    m_cam = val[59:0];
      bqe_pkg::RegWidth:  m_width = val[19:0];
      bqe_pkg::RegHeight: m_height = val[19:0];
      default: ;
    endcase
  endtask

  task automatic add_sprite(int x, int y, int z, bit first);
    sprite_t s;
    s.x = x[bqe_pkg::PosW-1:0];
    s.y = y[bqe_pkg::PosW-1:0];
    s.z = z[bqe_pkg::PosW-1:0];
    s.first = first;
    sprites_waiting.push_back(s);
  endtask

  function automatic logic [47:0] pick_vector();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {16'h8000, 16'h8000, 16'h8000};
      2: return {16'h7fff, 16'h7fff, 16'h7fff};
      3: return {16'(0), 16'(0), 16'($urandom_range(1, 3))};
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [19:0] pick_size();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 20'hfffff;
      2: return 20'($urandom);
      default: return 20'($urandom_range(0, 4096));
    endcase
  endfunction

  initial begin
    logic [59:0] cam;
    int nx, nz;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, field extremes and batch restarts
    add_sprite(0, 0, 0, 1);
    add_sprite(524287, 524287, 524287, 0);
    add_sprite(-524288, -524288, -524288, 0);
    add_sprite(524287, -524288, 0, 1);
    add_sprite(-1, 1, -256, 0);
    add_sprite(1000, -2000, 3000, 0);
    add_sprite(-524288, 524287, 12345, 1);
    wait_drained();

    // zero right vector, width and height at their maximum, saturating corners
    write_reg(bqe_pkg::RegRight, '0);
    write_reg(bqe_pkg::RegUp, bqe_pkg::CfgW'({16'h8000, 16'h7fff, 16'h8000}));
    write_reg(bqe_pkg::RegWidth, bqe_pkg::CfgW'(20'hfffff));
    write_reg(bqe_pkg::RegHeight, bqe_pkg::CfgW'(20'hfffff));
    write_reg(RegUnused, {bqe_pkg::CfgW{1'b1}});
    add_sprite(524287, 524287, 524287, 0);
    add_sprite(-524288, -524288, -524288, 0);
    add_sprite(0, 0, 0, 0);
    add_sprite(300000, -300000, 7, 1);
    wait_drained();

    // locked axis: camera straight above and at the extremes
    write_reg(bqe_pkg::RegMode, bqe_pkg::CfgW'(1'b1));
    write_reg(bqe_pkg::RegCam, {20'h80000, 20'h7ffff, 20'h80000});
    write_reg(bqe_pkg::RegHeight, '0);
    write_reg(bqe_pkg::RegWidth, bqe_pkg::CfgW'(20'd512));
    add_sprite(-524288, 0, -524288, 0);
    add_sprite(524287, 5, 524287, 0);
    add_sprite(-524288, -9, 524287, 1);
    add_sprite(0, 100, 0, 0);
    add_sprite(-524288, 524287, -524287, 0);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph % 3 == 2);
      if (ph == 8) tail = 1;
      write_reg(bqe_pkg::RegMode, bqe_pkg::CfgW'($urandom_range(0, 1)));
      write_reg(bqe_pkg::RegRight, bqe_pkg::CfgW'(pick_vector()));
      write_reg(bqe_pkg::RegUp, bqe_pkg::CfgW'(pick_vector()));
      cam = 60'({$urandom, $urandom});
      write_reg(bqe_pkg::RegCam, cam);
      write_reg(bqe_pkg::RegWidth, bqe_pkg::CfgW'(pick_size()));
      write_reg(bqe_pkg::RegHeight, bqe_pkg::CfgW'(pick_size()));
      if ($urandom_range(0, 3) == 0) write_reg(RegBeyond, bqe_pkg::CfgW'({$urandom, $urandom}));
      for (int i = 0; i < 55; i++) begin
        nx = int'($signed(m_cam[19:0]));
        nz = int'($signed(m_cam[59:40]));
        case ($urandom_range(0, 9))
          // sprite right under the camera
          0: add_sprite(nx, $urandom, nz, $urandom_range(0, 7) == 0);
          1: add_sprite(nx + $urandom_range(0, 4) - 2, $urandom, nz + $urandom_range(0, 4) - 2,
                        $urandom_range(0, 7) == 0);
          default: add_sprite($urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
        endcase
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (corners_due.size() != 0) report("corners never delivered");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[billboard_quad_expander.f]
rtl/core/bqe_pkg.sv
rtl/core/bqe_ctrl.sv
rtl/core/bqe_dp.sv
rtl/core/billboard_quad_expander.sv
test/tb_billboard_quad_expander.sv
